// ===== rtl/spmq_pkg.sv =====
// shared types, codes and widths for the strict priority multi queue
package spmq_pkg;

    // field widths
    localparam int PAYLOAD_W = 64;
    localparam int LEN_W     = 4;
    localparam int QSEL_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int OP_W      = 1;
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 4;

    // parameter defaults
    localparam int DEF_RECEIVE_DEPTH     = 16;
    localparam int DEF_STREAM_DEPTH      = 16;
    localparam int DEF_ERROR_DEPTH       = 16;
    localparam int DEF_STREAM_PRESENT    = 1;
    localparam int DEF_MAX_PAYLOAD_BYTES = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_READ  = 1'b1;

    // queue codes
    localparam logic [QSEL_W-1:0] Q_RECEIVE = 2'd0;
    localparam logic [QSEL_W-1:0] Q_STREAM  = 2'd1;
    localparam logic [QSEL_W-1:0] Q_ERROR   = 2'd2;
    localparam logic [QSEL_W-1:0] Q_INVALID = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic respond;
    } spmq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } spmq_stat_t;

endpackage

// ===== rtl/spmq_ring.sv =====
// one ring buffer queue: entry memory with read and write pointers
module spmq_ring
    import spmq_pkg::*;
#(
    parameter int DEPTH   = DEF_RECEIVE_DEPTH,
    parameter int ENTRY_W = 8 * DEF_MAX_PAYLOAD_BYTES + LEN_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               pop,
    input  logic [ENTRY_W-1:0] wdata,
    output logic [ENTRY_W-1:0] rdata,
    output logic               empty,
    output logic               full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic [PTR_W-1:0]   rd_reg;
    logic [PTR_W-1:0]   rd_next;
    logic [PTR_W-1:0]   wr_reg;
    logic [PTR_W-1:0]   wr_next;
    logic [PTR_W-1:0]   rd_inc;
    logic [PTR_W-1:0]   wr_inc;

    // wrapping pointer increments
    assign rd_inc = (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
    assign wr_inc = (wr_reg == LAST) ? '0 : wr_reg + 1'b1;

    // one slot stays free so full and empty differ
    assign empty = (rd_reg == wr_reg);
    assign full  = (wr_inc == rd_reg);

    assign rd_next = pop  ? rd_inc : rd_reg;
    assign wr_next = push ? wr_inc : wr_reg;

    // pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
        end
        else
        begin
            rd_reg <= rd_next;
            wr_reg <= wr_next;
        end
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= wdata;
        end
        if (pop)
        begin
            rdata_reg <= mem[rd_reg];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/spmq_dp.sv =====
// datapath: item registers, the three queues, priority pick and result register
module spmq_dp
    import spmq_pkg::*;
#(
    parameter int RECEIVE_DEPTH     = DEF_RECEIVE_DEPTH,
    parameter int STREAM_DEPTH      = DEF_STREAM_DEPTH,
    parameter int ERROR_DEPTH       = DEF_ERROR_DEPTH,
    parameter int STREAM_PRESENT    = DEF_STREAM_PRESENT,
    parameter int MAX_PAYLOAD_BYTES = DEF_MAX_PAYLOAD_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  spmq_cmd_t            cmd,
    output spmq_stat_t           stat,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    localparam int DATA_W  = 8 * MAX_PAYLOAD_BYTES;
    localparam int ENTRY_W = DATA_W + LEN_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD_BYTES);

    // captured item
    logic [OP_W-1:0]      op_reg;
    logic [QSEL_W-1:0]    qsel_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [LEN_W-1:0]     len_reg;

    // execution outcome
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [QSEL_W-1:0]    src_reg;
    logic [QSEL_W-1:0]    src_next;
    logic                 hit_reg;
    logic                 hit_next;

    // result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TUSER_W-1:0] out_user_reg;

    logic [LEN_W-1:0]     len_clip;
    logic [DATA_W-1:0]    data_kept;
    logic [ENTRY_W-1:0]   wentry;
    logic                 invalid_sel;
    logic [2:0]           push;
    logic [2:0]           pop;
    logic [2:0]           empty;
    logic [2:0]           full;
    logic [ENTRY_W-1:0]   rdata [3];
    logic [ENTRY_W-1:0]   rsel;
    logic [PAYLOAD_W-1:0] res_payload;
    logic [LEN_W-1:0]     res_len;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= s_axis_tuser[0];
            qsel_reg    <= s_axis_tuser[2:1];
            payload_reg <= s_axis_tdata[PAYLOAD_W-1:0];
            len_reg     <= s_axis_tdata[PAYLOAD_W+LEN_W-1:PAYLOAD_W];
        end
    end

    // length clip and byte masking of the stored payload
    assign len_clip = (len_reg > MAX_LEN) ? MAX_LEN : len_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_PAYLOAD_BYTES; i++)
        begin
            data_kept[8*i +: 8] = (LEN_W'(i) < len_clip) ? payload_reg[8*i +: 8] : 8'h00;
        end
    end

    assign wentry = {len_clip, data_kept};

    assign invalid_sel = (qsel_reg == Q_INVALID) ||
                         ((qsel_reg == Q_STREAM) && (STREAM_PRESENT == 0));

    // write target check or read priority pick
    always_comb
    begin
        status_next = ST_OK;
        src_next    = Q_RECEIVE;
        hit_next    = 1'b0;
        push        = 3'b000;
        pop         = 3'b000;
        if (op_reg == OP_WRITE)
        begin
            if (invalid_sel)
            begin
                status_next = ST_INVALID;
            end
            else if (full[qsel_reg])
            begin
                status_next = ST_FULL;
            end
            else
            begin
                push[qsel_reg] = cmd.exec;
            end
        end
        else
        begin
            if (!empty[0])
            begin
                src_next = Q_RECEIVE;
                hit_next = 1'b1;
                pop[0]   = cmd.exec;
            end
            else if (!empty[1])
            begin
                src_next = Q_STREAM;
                hit_next = 1'b1;
                pop[1]   = cmd.exec;
            end
            else if (!empty[2])
            begin
                src_next = Q_ERROR;
                hit_next = 1'b1;
                pop[2]   = cmd.exec;
            end
            else
            begin
                status_next = ST_EMPTY;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            src_reg    <= src_next;
            hit_reg    <= hit_next;
        end
    end

    // receive queue
    spmq_ring #(
        .DEPTH   (RECEIVE_DEPTH),
        .ENTRY_W (ENTRY_W)
    ) u_receive (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push[0]),
        .pop   (pop[0]),
        .wdata (wentry),
        .rdata (rdata[0]),
        .empty (empty[0]),
        .full  (full[0])
    );

    // stream queue, only when built in
    generate
        if (STREAM_PRESENT != 0)
        begin : g_stream
            spmq_ring #(
                .DEPTH   (STREAM_DEPTH),
                .ENTRY_W (ENTRY_W)
            ) u_stream (
                .clk   (clk),
                .rst_n (rst_n),
                .push  (push[1]),
                .pop   (pop[1]),
                .wdata (wentry),
                .rdata (rdata[1]),
                .empty (empty[1]),
                .full  (full[1])
            );
        end
        else
        begin : g_no_stream
            assign rdata[1] = '0;
            assign empty[1] = 1'b1;
            assign full[1]  = 1'b1;
        end
    endgenerate

    // error queue
    spmq_ring #(
        .DEPTH   (ERROR_DEPTH),
        .ENTRY_W (ENTRY_W)
    ) u_error (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push[2]),
        .pop   (pop[2]),
        .wdata (wentry),
        .rdata (rdata[2]),
        .empty (empty[2]),
        .full  (full[2])
    );

    // result fields, zero unless a read hit
    assign rsel        = (src_reg == Q_INVALID) ? '0 : rdata[src_reg];
    assign res_payload = hit_reg ? PAYLOAD_W'(rsel[DATA_W-1:0]) : '0;
    assign res_len     = hit_reg ? rsel[ENTRY_W-1:DATA_W] : '0;

    assign stat.out_free = !out_valid_reg || m_axis_tready;

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.respond)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            out_data_reg <= {{(M_TDATA_W-PAYLOAD_W-LEN_W){1'b0}}, res_len, res_payload};
            out_user_reg <= {(hit_reg ? src_reg : Q_RECEIVE), status_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ===== rtl/spmq_ctrl.sv =====
// controller: sequences capture, execution and result hand-off per item
module spmq_ctrl
    import spmq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  spmq_stat_t stat,
    output spmq_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/strict_priority_multi_queue.sv =====
// Strict priority multi queue: receive, stream and error rings of short payloads.
// Slave channel: s_axis_* carries one command per transfer, a push (write) of a
// payload into a named queue or a pop (read) of the highest priority entry.
// Master channel: m_axis_* returns exactly one result per command: a status,
// and for a successful pop the payload, its length and the source queue.
// Pops serve receive first, then stream, then error.
// A command is captured into the item registers, executed into the status registers
// and then loaded into the output register; commands are taken one at a time, as the
// controller steps through capture, execute and respond before it accepts another;
// execute does the pointer update and the registered read of the queue memory.
// Reset empties all queues (pointers to zero); memory contents are not cleared.
// When the receiver stalls, the finished result waits in the output register
// and one further command is accepted and executed; its result then waits until
// the output register is taken.
module strict_priority_multi_queue
    import spmq_pkg::*;
#(
    parameter int RECEIVE_DEPTH     = DEF_RECEIVE_DEPTH,
    parameter int STREAM_DEPTH      = DEF_STREAM_DEPTH,
    parameter int ERROR_DEPTH       = DEF_ERROR_DEPTH,
    parameter int STREAM_PRESENT    = DEF_STREAM_PRESENT,
    parameter int MAX_PAYLOAD_BYTES = DEF_MAX_PAYLOAD_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // payload [63:0], payload_length [67:64], zero fill [71:68]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // op [0], queue_select [2:1]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // read_payload [63:0], read_length [67:64], zero fill [71:68]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // status [1:0], read_queue [3:2]
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    spmq_cmd_t  cmd;
    spmq_stat_t stat;

    // control sequencer
    spmq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // queues and result path
    spmq_dp #(
        .RECEIVE_DEPTH     (RECEIVE_DEPTH),
        .STREAM_DEPTH      (STREAM_DEPTH),
        .ERROR_DEPTH       (ERROR_DEPTH),
        .STREAM_PRESENT    (STREAM_PRESENT),
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // an accepted command is executed in the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> cmd.exec)
        else $error("accepted command not executed");

    // no new command is taken right after execution
    a_exec_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !s_axis_tready)
        else $error("input ready while result pending");

    // failed commands carry zero read fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] != ST_OK) |->
            (m_axis_tdata == '0) && (m_axis_tuser[3:2] == Q_RECEIVE))
        else $error("nonzero read fields on failed command");

    // popped length never exceeds the entry size
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[PAYLOAD_W+LEN_W-1:PAYLOAD_W] <= LEN_W'(MAX_PAYLOAD_BYTES)))
        else $error("read length above maximum");

endmodule

// ===== test/spmq_result_checker.sv =====
// result checker for the strict priority multi queue: models the three rings and compares results
module spmq_result_checker
    import spmq_pkg::*;
#(
    parameter int RECEIVE_DEPTH     = DEF_RECEIVE_DEPTH,
    parameter int STREAM_DEPTH      = DEF_STREAM_DEPTH,
    parameter int ERROR_DEPTH       = DEF_ERROR_DEPTH,
    parameter int STREAM_PRESENT    = DEF_STREAM_PRESENT,
    parameter int MAX_PAYLOAD_BYTES = DEF_MAX_PAYLOAD_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // payload [63:0], payload_length [67:64], zero fill [71:68]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // op [0], queue_select [2:1]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // read_payload [63:0], read_length [67:64], zero fill [71:68]
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    // status [1:0], read_queue [3:2]
    input  logic [M_TUSER_W-1:0] m_axis_tuser,
    output int                   fail_count,
    output int                   outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH_RS  = (RECEIVE_DEPTH > STREAM_DEPTH) ? RECEIVE_DEPTH : STREAM_DEPTH;
    localparam int MAX_DEPTH = (DEPTH_RS > ERROR_DEPTH) ? DEPTH_RS : ERROR_DEPTH;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [PAYLOAD_W-1:0] payload;
        logic [LEN_W-1:0]     length;
        logic [QSEL_W-1:0]    queue;
    } queue_outcome_t;

    // ring contents and pointers, one row per queue
    logic [PAYLOAD_W-1:0] slot_bytes [3][MAX_DEPTH];
    logic [LEN_W-1:0]     slot_len   [3][MAX_DEPTH];
    int unsigned          rd_ptr     [3];
    int unsigned          wr_ptr     [3];
    int unsigned          ring_depth [3];

    queue_outcome_t awaited_results [$];

    // push or pop on the ring model, giving the result the block must return
    task automatic apply_command(
        input  logic                 op,
        input  logic [QSEL_W-1:0]    sel,
        input  logic [PAYLOAD_W-1:0] data,
        input  logic [LEN_W-1:0]     len,
        output queue_outcome_t       res
    );
        int unsigned          nbytes;
        int unsigned          nxt;
        int                   qi;
        logic [PAYLOAD_W-1:0] mask;
        logic                 served;
        res.status  = ST_OK;
        res.payload = '0;
        res.length  = '0;
        res.queue   = Q_RECEIVE;
        qi = int'(sel);
        if (op == OP_WRITE) begin
            // overlong lengths are clipped, bytes beyond the length dropped
            nbytes = len;
            if (nbytes > MAX_PAYLOAD_BYTES)
                nbytes = MAX_PAYLOAD_BYTES;
            if (nbytes >= 8)
                mask = '1;
            else
                mask = (64'd1 << (8 * nbytes)) - 64'd1;
            if (sel == Q_INVALID || (sel == Q_STREAM && STREAM_PRESENT == 0)) begin
                res.status = ST_INVALID;
            end
            else begin
                nxt = (wr_ptr[qi] + 1) % ring_depth[qi];
                if (nxt == rd_ptr[qi]) begin
                    res.status = ST_FULL;
                end
                else begin
                    slot_bytes[qi][wr_ptr[qi]] = data & mask;
                    slot_len[qi][wr_ptr[qi]]   = LEN_W'(nbytes);
                    wr_ptr[qi] = nxt;
                end
            end
        end
        else begin
            // strict priority: receive, then stream, then error
            res.status = ST_EMPTY;
            served = 1'b0;
            for (int q = 0; q < 3; q++) begin
                if (!served && !(q == int'(Q_STREAM) && STREAM_PRESENT == 0)
                        && rd_ptr[q] != wr_ptr[q]) begin
                    res.status  = ST_OK;
                    res.payload = slot_bytes[q][rd_ptr[q]];
                    res.length  = slot_len[q][rd_ptr[q]];
                    res.queue   = QSEL_W'(q);
                    rd_ptr[q]   = (rd_ptr[q] + 1) % ring_depth[q];
                    served      = 1'b1;
                end
            end
        end
    endtask

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
        end
    endfunction

    // watch both channels; results are compared before the new command is modeled
    always @(posedge clk or negedge rst_n) begin : watch
        queue_outcome_t got;
        queue_outcome_t want;
        queue_outcome_t res;
        if (!rst_n) begin
            fail_count = 0;
            ring_depth[0] = RECEIVE_DEPTH;
            ring_depth[1] = STREAM_DEPTH;
            ring_depth[2] = ERROR_DEPTH;
            for (int q = 0; q < 3; q++) begin
                rd_ptr[q] = 0;
                wr_ptr[q] = 0;
            end
            awaited_results.delete();
            outstanding = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.payload = m_axis_tdata[63:0];
                got.length  = m_axis_tdata[67:64];
                got.status  = m_axis_tuser[1:0];
                got.queue   = m_axis_tuser[3:2];
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    $error("result transfer with none awaited: status %0d payload 0x%0h",
                           got.status, got.payload);
                end
                else begin
                    want = awaited_results.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("read_payload", want.payload, got.payload);
                    check_field("read_length", 64'(want.length), 64'(got.length));
                    check_field("read_queue", 64'(want.queue), 64'(got.queue));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_command(s_axis_tuser[0], s_axis_tuser[2:1], s_axis_tdata[63:0],
                              s_axis_tdata[67:64], res);
                awaited_results.push_back(res);
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

// ===== test/tb_strict_priority_multi_queue.sv =====
// testbench top for the strict priority multi queue: stimulus, flow pacing and verdict
module tb_strict_priority_multi_queue;

    import spmq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 410;
    localparam int SETTLE_CYCLES   = 10;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // payload [63:0], payload_length [67:64], zero fill [71:68]
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // op [0], queue_select [2:1]
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // read_payload [63:0], read_length [67:64], zero fill [71:68]
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // status [1:0], read_queue [3:2]
    logic [M_TUSER_W-1:0] m_axis_tuser;

    int fail_count;
    int outstanding;
    int feed_idle_pct = 0;
    int sink_stall_pct = 0;
    int cycle_count = 0;

    // idle mix per phase: none, sender only, receiver only, both
    int feed_mix [4] = '{0, 49, 0, 31};
    int sink_mix [4] = '{0, 0, 49, 31};

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    strict_priority_multi_queue i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    spmq_result_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // receiver backpressure
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one command transfer, with random idle cycles ahead of it; entered and left at a falling edge
    task automatic send_command(
        input logic                 op,
        input logic [QSEL_W-1:0]    sel,
        input logic [PAYLOAD_W-1:0] data,
        input logic [LEN_W-1:0]     len
    );
        while ($urandom_range(0, 99) < feed_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {sel, op};
        s_axis_tdata  <= {4'b0000, len, data};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold off the sender until every awaited result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // bursts with a random write share and a favored queue, so rings fill, wrap and run dry
    task automatic random_phase(input int items);
        int                   remaining;
        int                   burst;
        int                   write_pct;
        int                   pick;
        logic [QSEL_W-1:0]    favored;
        logic                 op;
        logic [QSEL_W-1:0]    sel;
        logic [PAYLOAD_W-1:0] data;
        logic [LEN_W-1:0]     len;
        remaining = items;
        while (remaining > 0)
        begin
            burst = $urandom_range(1, 40);
            case ($urandom_range(0, 2))
                0:       write_pct = 90;
                1:       write_pct = 50;
                default: write_pct = 15;
            endcase
            favored = QSEL_W'($urandom_range(0, 2));
            for (int k = 0; k < burst && remaining > 0; k++)
            begin
                op = ($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_READ;
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    sel = Q_INVALID;
                else if (pick < 60)
                    sel = favored;
                else
                    sel = QSEL_W'($urandom_range(0, 2));
                if ($urandom_range(0, 99) < 10)
                    len = LEN_W'($urandom_range(9, 15));
                else
                    len = LEN_W'($urandom_range(0, 8));
                case ($urandom_range(0, 9))
                    0:       data = '0;
                    1:       data = '1;
                    default: data = {$urandom, $urandom};
                endcase
                send_command(op, sel, data, len);
                remaining--;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty read, invalid queue, clipping, zero length, priority order
        send_command(OP_READ, Q_RECEIVE, '1, 4'hf);
        send_command(OP_WRITE, Q_INVALID, '1, 4'd8);
        send_command(OP_WRITE, Q_ERROR, 64'h0123_4567_89ab_cdef, 4'd3);
        send_command(OP_WRITE, Q_STREAM, '1, 4'hf);
        send_command(OP_WRITE, Q_RECEIVE, '1, 4'd0);
        send_command(OP_WRITE, Q_RECEIVE, '1, 4'd8);
        send_command(OP_WRITE, Q_RECEIVE, '0, 4'd8);
        send_command(OP_WRITE, Q_STREAM, 64'ha5a5_5a5a_c3c3_3c3c, 4'd1);
        send_command(OP_WRITE, Q_ERROR, '1, 4'd9);
        repeat (8)
            send_command(OP_READ, Q_INVALID, '1, 4'hf);
        send_command(OP_WRITE, Q_ERROR, '0, 4'd0);
        send_command(OP_READ, Q_STREAM, '0, 4'd0);
        send_command(OP_READ, Q_ERROR, '0, 4'd0);
        drain_results();

        // random phases under different idle mixes
        for (int p = 0; p < 4; p++)
        begin
            feed_idle_pct  = feed_mix[p];
            sink_stall_pct = sink_mix[p];
            random_phase(ITEMS_PER_PHASE);
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spmq_pkg.sv
rtl/spmq_ring.sv
rtl/spmq_dp.sv
rtl/spmq_ctrl.sv
rtl/strict_priority_multi_queue.sv
test/spmq_result_checker.sv
test/tb_strict_priority_multi_queue.sv
